>>> hw/rtl/phnorm_pkg.sv
`default_nettype none
package phnorm_pkg;

  localparam int NUM_LIGHTS       = 8;
  localparam int MAX_LIGHTS       = 8;
  localparam int WEIGHT_FRAC_BITS = 12;
  localparam int W_W              = 48;
  localparam int CFG_IDX_W        = 8;
  localparam int IN_W             = 72;
  localparam int OUT_W            = 24;

  // |g| < 2^26 for eight lights; one more bit for sign, one spare
  localparam int G_W  = 28;
  localparam int SQ_W = 2 * G_W;
  localparam int S_W  = SQ_W + 2;
  localparam int A_W  = SQ_W + 16;
  localparam int B_W  = S_W + 16;

  localparam logic [63:0] NEAR_ZERO_FULL =
    (64'd65025 << (2 * WEIGHT_FRAC_BITS)) / 64'd1000000000000;
  localparam logic [S_W-1:0] NEAR_ZERO_SQ = NEAR_ZERO_FULL[S_W-1:0];

  typedef struct packed {
    logic signed [G_W-1:0] g;
    logic [A_W-1:0]        a;   // 65025 * g^2
    logic [7:0]            b;   // byte built so far, MSB first
  } lane_t;

  typedef struct packed {
    logic            vld;
    logic            nz;
    logic [S_W-1:0]  s;
    lane_t [2:0]     lane;  // 0 x, 1 y, 2 z
  } stp_t;

endpackage
`default_nettype wire

>>> hw/rtl/phnorm_step.sv
`default_nettype none
module phnorm_step #(
  parameter int BIT_POS = 7
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                en,
  input  phnorm_pkg::stp_t   st_i,
  output phnorm_pkg::stp_t   st_o
);

  localparam logic [7:0] BIT_MASK = 8'(1 << BIT_POS);

  phnorm_pkg::stp_t s1_r, s2_r, st_r;
  logic [15:0]                  dsq_r [3];
  logic [15:0]                  dsq_nxt [3];
  logic [phnorm_pkg::B_W-1:0]   bp_r [3];
  phnorm_pkg::stp_t             st_nxt;

  // stage 1: square of |d| for the candidate byte
  always_comb begin
    logic [7:0] t;
    logic [8:0] ad;
    for (int c = 0; c < 3; c++) begin
      t  = st_i.lane[c].b | BIT_MASK;
      ad = t[7] ? {1'b0, t[6:0], 1'b0} : (9'd256 - {t, 1'b0});
      dsq_nxt[c] = 16'(ad * ad);
    end
  end

  // stage 3: decide this bit from sign of 255*g - d*sqrt(s)
  always_comb begin
    logic [7:0] t;
    logic       gzr, gneg, gpos, dzr, dneg, gt, eq, take;
    logic [phnorm_pkg::B_W-1:0] a;
    st_nxt = s2_r;
    for (int c = 0; c < 3; c++) begin
      t    = s2_r.lane[c].b | BIT_MASK;
      gzr  = (s2_r.lane[c].g == '0);
      gneg = s2_r.lane[c].g[phnorm_pkg::G_W-1];
      gpos = !gneg && !gzr;
      dzr  = (t == 8'd128);
      dneg = !t[7];
      a    = phnorm_pkg::B_W'(s2_r.lane[c].a);
      if (!gneg && (dneg || dzr)) begin
        gt = !(gzr && dzr);
        eq = gzr && dzr;
      end else if (!gpos && !dneg) begin
        gt = 1'b0;
        eq = 1'b0;
      end else if (gpos) begin
        gt = a > bp_r[c];
        eq = a == bp_r[c];
      end else begin
        gt = bp_r[c] > a;
        eq = a == bp_r[c];
      end
      take = gt || (eq && !t[0]);
      st_nxt.lane[c].b = take ? t : s2_r.lane[c].b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld <= 1'b0;
      s2_r.vld <= 1'b0;
      st_r.vld <= 1'b0;
    end else if (en) begin
      s1_r <= st_i;
      s2_r <= s1_r;
      st_r <= st_nxt;
      for (int c = 0; c < 3; c++) begin
        dsq_r[c] <= dsq_nxt[c];
        bp_r[c]  <= phnorm_pkg::B_W'(dsq_r[c]) * phnorm_pkg::B_W'(s1_r.s);
      end
    end
  end

  assign st_o = st_r;

endmodule
`default_nettype wire

>>> hw/rtl/photometric_normal_per_pixel_top.sv
`default_nettype none
// Throughput: one pixel item per cycle; the whole pipeline holds while a
// result waits on out_tready. Masked pixels leave a bubble and no result.
// The byte search takes eight 3-stage steps (square, multiply, compare).
// Reset (rst_n low, synchronous): light weights clear to zero, all valid bits drop.
module photometric_normal_per_pixel_top #(
  parameter int NUM_LIGHTS = phnorm_pkg::NUM_LIGHTS
) (
  input  wire                                clk,
  input  wire                                rst_n,
  // mask_level, intensity_0 .. intensity_7, 8 bits each from the LSB
  input  wire [phnorm_pkg::IN_W-1:0]         in_tdata,
  input  wire                                in_tvalid,
  output logic                               in_tready,
  // blue_z [7:0], green_y [15:8], red_x [23:16]
  output logic [phnorm_pkg::OUT_W-1:0]       out_tdata,
  output logic                               out_tvalid,
  input  wire                                out_tready,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire [phnorm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [phnorm_pkg::W_W-1:0]          cfg_data
);

  localparam int IW = (NUM_LIGHTS > 1) ? $clog2(NUM_LIGHTS) : 1;
  localparam int G_W = phnorm_pkg::G_W;

  logic en;

  // light weight registers, one 48-bit word per light
  logic [phnorm_pkg::W_W-1:0] wt_r [NUM_LIGHTS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < NUM_LIGHTS; l++) wt_r[l] <= '0;
    end else if (cfg_valid && (cfg_index < phnorm_pkg::CFG_IDX_W'(NUM_LIGHTS))) begin
      wt_r[cfg_index[IW-1:0]] <= cfg_data;
    end
  end

  // advance everything unless the output item is held
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // stage 1: weight times intensity per light and axis
  logic                  v1_r;
  logic signed [24:0]    prod_r [NUM_LIGHTS][3];

  // stage 2: accumulate over lights
  logic                  v2_r;
  logic signed [G_W-1:0] g2_r [3];
  logic signed [G_W-1:0] g2_nxt [3];

  // stage 3: squares
  logic                  v3_r;
  logic signed [G_W-1:0] g3_r [3];
  logic [phnorm_pkg::SQ_W-1:0] sq3_r [3];

  // stage 4: |g|^2 and 65025*g^2
  logic                  v4_r;
  logic signed [G_W-1:0] g4_r [3];
  logic [phnorm_pkg::S_W-1:0] s4_r;
  logic [phnorm_pkg::A_W-1:0] a4_r [3];

  // stage 5: near-zero test, head of the byte search
  phnorm_pkg::stp_t chain [9];
  phnorm_pkg::stp_t st0_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      g2_nxt[c] = '0;
      for (int l = 0; l < NUM_LIGHTS; l++) begin
        g2_nxt[c] = g2_nxt[c] + G_W'(prod_r[l][c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      v4_r      <= 1'b0;
      st0_r.vld <= 1'b0;
    end else if (en) begin
      v1_r      <= in_tvalid && !in_tdata[7];  // drop masked pixels here
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      v4_r      <= v3_r;
      st0_r.vld <= v4_r;
      st0_r.nz  <= (s4_r <= phnorm_pkg::NEAR_ZERO_SQ);
      st0_r.s   <= s4_r;
      for (int c = 0; c < 3; c++) begin
        st0_r.lane[c].g <= g4_r[c];
        st0_r.lane[c].a <= a4_r[c];
        st0_r.lane[c].b <= 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NUM_LIGHTS; l++) begin
        for (int c = 0; c < 3; c++) begin
          prod_r[l][c] <= 25'($signed(wt_r[l][16*c +: 16]) *
                              $signed({1'b0, in_tdata[8 + 8*l +: 8]}));
        end
      end
      for (int c = 0; c < 3; c++) begin
        g2_r[c]  <= g2_nxt[c];
        g3_r[c]  <= g2_r[c];
        sq3_r[c] <= phnorm_pkg::SQ_W'(g2_r[c] * g2_r[c]);
        g4_r[c]  <= g3_r[c];
        // 65025 = 2^16 - 2^9 + 1
        a4_r[c]  <= (phnorm_pkg::A_W'(sq3_r[c]) << 16) - (phnorm_pkg::A_W'(sq3_r[c]) << 9)
                    + phnorm_pkg::A_W'(sq3_r[c]);
      end
      s4_r <= phnorm_pkg::S_W'(sq3_r[0]) + phnorm_pkg::S_W'(sq3_r[1])
              + phnorm_pkg::S_W'(sq3_r[2]);
    end
  end

  assign chain[0] = st0_r;

  // eight search steps, one output bit each, MSB first
  for (genvar k = 0; k < 8; k++) begin : g_step
    phnorm_step #(
      .BIT_POS (7 - k)
    ) u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .st_i  (chain[k]),
      .st_o  (chain[k+1])
    );
  end

  // output register
  logic                          out_valid_r;
  logic [phnorm_pkg::OUT_W-1:0]  out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= chain[8].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (chain[8].nz) begin
        out_data_r <= {8'd128, 8'd128, 8'd255};
      end else begin
        out_data_r <= {chain[8].lane[0].b, chain[8].lane[1].b, chain[8].lane[2].b};
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

>>> hw/rtl/phnorm_chk.sv
`default_nettype none
module phnorm_chk (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              in_tready,
  input wire [phnorm_pkg::OUT_W-1:0]      out_tdata,
  input wire                              out_tvalid,
  input wire                              out_tready,
  input wire                              cfg_valid,
  input wire                              cfg_ready
);

  // held result keeps its value until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  // a held result stalls the input side
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted while output stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // configuration never waits
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind photometric_normal_per_pixel_top phnorm_chk u_phnorm_chk (.*);
`default_nettype wire

>>> verif/tb_photometric_normal_per_pixel_top.sv
`default_nettype none
module tb_photometric_normal_per_pixel_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_LIGHTS = 8;
  // cycles from an accepted item to its result, plus margin for masked items
  localparam int PIPE_DRAIN = 40;
  localparam int HOLD_LEN = 150;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [phnorm_pkg::IN_W-1:0] in_tdata = '0;
  logic in_tvalid = 1'b0;
  wire in_tready;
  wire [phnorm_pkg::OUT_W-1:0] out_tdata;
  wire out_tvalid;
  logic out_tready = 1'b0;
  logic cfg_valid = 1'b0;
  wire cfg_ready;
  logic [phnorm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [phnorm_pkg::W_W-1:0] cfg_data = '0;

  photometric_normal_per_pixel_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // shadow copy of the light weight registers
  logic [phnorm_pkg::W_W-1:0] light_wt [N_LIGHTS];
  // expected result bytes: {red_x, green_y, blue_z}
  logic [phnorm_pkg::OUT_W-1:0] normal_q [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int mismatches = 0;

  // round-half-even of 127.5 * (1 + g / sqrt(s)), done with exact integer compares
  function automatic logic [7:0] normal_byte(longint g, longint unsigned s);
    int cnt;
    int c;
    longint d;
    longint unsigned mg, md;
    logic [127:0] lhs, rhs;
    cnt = 0;
    for (int m = 0; m < 255; m++) begin
      d = 2 * m - 254;
      if (g >= 0 && d <= 0) begin
        c = (g == 0 && d == 0) ? 0 : 1;
      end else if (g <= 0 && d >= 0) begin
        c = -1;
      end else begin
        mg = (g < 0) ? -g : g;
        md = (d < 0) ? -d : d;
        lhs = 128'(mg * mg) * 128'd65025;
        rhs = 128'(md * md) * 128'(s);
        c = (lhs > rhs) ? 1 : ((lhs == rhs) ? 0 : -1);
        if (g < 0) c = -c;
      end
      if (c > 0 || (c == 0 && m[0])) cnt++;
    end
    return cnt[7:0];
  endfunction

  // expected normal bytes of one pixel; returns 0 for a masked pixel
  function automatic bit predict_normal(input logic [phnorm_pkg::IN_W-1:0] px,
                                        output logic [phnorm_pkg::OUT_W-1:0] rgb);
    longint gx, gy, gz, v, wx, wy, wz;
    longint unsigned s;
    gx = 0; gy = 0; gz = 0;
    rgb = '0;
    if (px[7:0] > 8'd127) return 0;
    for (int l = 0; l < phnorm_pkg::NUM_LIGHTS; l++) begin
      v  = longint'(px[8 + 8*l +: 8]);
      wx = longint'(shortint'(light_wt[l][15:0]));
      wy = longint'(shortint'(light_wt[l][31:16]));
      wz = longint'(shortint'(light_wt[l][47:32]));
      gx += wx * v;
      gy += wy * v;
      gz += wz * v;
    end
    s = longint'(gx * gx) + longint'(gy * gy) + longint'(gz * gz);
    if (s <= longint'(phnorm_pkg::NEAR_ZERO_SQ)) begin
      // too short to normalize: straight-up normal
      rgb = {8'd128, 8'd128, 8'd255};
    end else begin
      rgb = {normal_byte(gx, s), normal_byte(gy, s), normal_byte(gz, s)};
    end
    return 1;
  endfunction

  // offer one pixel item, predict on acceptance
  task automatic send_pixel(input logic [phnorm_pkg::IN_W-1:0] px);
    logic [phnorm_pkg::OUT_W-1:0] rgb;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tdata  <= px;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (predict_normal(px, rgb)) normal_q = {normal_q, rgb};
  endtask

  task automatic stop_sending();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // wait until every result is back and masked items have left the pipe
  task automatic drain();
    stop_sending();
    while (normal_q.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(input int idx, input logic [phnorm_pkg::W_W-1:0] val);
    cfg_index <= idx[phnorm_pkg::CFG_IDX_W-1:0];
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx < N_LIGHTS) light_wt[idx] = val;
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_weight();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'($urandom_range(8191)) - 16'd4096;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic load_random_weights();
    for (int l = 0; l < N_LIGHTS; l++)
      write_reg(l, {rand_weight(), rand_weight(), rand_weight()});
  endtask

  function automatic logic [phnorm_pkg::IN_W-1:0] rand_pixel();
    logic [phnorm_pkg::IN_W-1:0] px;
    px = phnorm_pkg::IN_W'({$urandom, $urandom, $urandom});
    // mostly unmasked pixels; some masked ones and some on the mask edge
    case ($urandom_range(9))
      0:       px[7:0] = 8'($urandom_range(255, 128));
      1:       px[7:0] = 8'd127;
      default: px[7:0] = 8'($urandom_range(127));
    endcase
    if ($urandom_range(7) == 0) px[phnorm_pkg::IN_W-1:8] = '0;
    return px;
  endfunction

  // check each result against the oldest expectation
  always @(posedge clk) begin
    logic [phnorm_pkg::OUT_W-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (normal_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_tdata);
      end else begin
        want = normal_q.pop_front();
        if (want[7:0] != out_tdata[7:0] || want[15:8] != out_tdata[15:8] ||
            want[23:16] != out_tdata[23:16]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("normal mismatch: expected b=%0d g=%0d r=%0d, got b=%0d g=%0d r=%0d",
                     want[7:0], want[15:8], want[23:16],
                     out_tdata[7:0], out_tdata[15:8], out_tdata[23:16]);
        end
      end
    end
  end

  // receiver: long hold-off on request, else random idling
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen  <= hold_req;
      hold_left  <= HOLD_LEN - 1;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
    end
  end

  // all-zero weights after reset give the straight-up normal
  task automatic test_reset_weights();
    send_pixel({64'hffff_ffff_ffff_ffff, 8'd0});
    send_pixel({64'h0123_4567_89ab_cdef, 8'd127});
    drain();
  endtask

  // axis-aligned weights, field extremes and the mask boundary
  task automatic test_directed();
    write_reg(0, {16'h0000, 16'h0000, 16'h1000});
    write_reg(1, {16'h0000, 16'h1000, 16'h0000});
    write_reg(2, {16'h1000, 16'h0000, 16'h0000});
    write_reg(3, {16'hf000, 16'hf000, 16'hf000});
    write_reg(4, {16'h7fff, 16'h7fff, 16'h7fff});
    write_reg(5, {16'h8000, 16'h8000, 16'h8000});
    write_reg(6, {16'h8000, 16'h7fff, 16'h0001});
    write_reg(7, {16'hffff, 16'h0001, 16'h8000});
    send_pixel({56'h0, 8'd255, 8'd0});
    send_pixel({48'h0, 8'd255, 8'd0, 8'd0});
    send_pixel({40'h0, 8'd255, 16'd0, 8'd0});
    send_pixel({32'h0, 8'd255, 24'd0, 8'd0});
    send_pixel({24'h0, 8'd255, 32'd0, 8'd0});
    send_pixel({16'h0, 8'd255, 40'd0, 8'd0});
    send_pixel({8'h0, 8'd255, 48'd0, 8'd0});
    send_pixel({8'd255, 56'd0, 8'd0});
    send_pixel({64'hffff_ffff_ffff_ffff, 8'd0});
    send_pixel({64'hffff_ffff_ffff_ffff, 8'd127});
    send_pixel({64'hffff_ffff_ffff_ffff, 8'd128});
    send_pixel({64'hffff_ffff_ffff_ffff, 8'd255});
    send_pixel({64'h0, 8'd0});
    send_pixel({64'h0101_0101_0101_0101, 8'd1});
    send_pixel({64'h00ff_00ff_00ff_00ff, 8'd64});
    send_pixel({64'hff00_ff00_ff00_ff00, 8'd64});
    send_pixel({56'h0, 8'd1, 8'd0});
    drain();
    // tiny vectors at and just above the near-zero bound
    write_reg(0, {16'h0000, 16'h0000, 16'h0001});
    for (int l = 1; l < N_LIGHTS; l++) write_reg(l, '0);
    send_pixel({56'h0, 8'd1, 8'd0});
    send_pixel({56'h0, 8'd2, 8'd0});
    drain();
  endtask

  // writes beyond the last register must leave the weights alone
  task automatic test_bad_index();
    load_random_weights();
    write_reg(8, '1);
    write_reg(255, 48'h8000_8000_8000);
    write_reg($urandom_range(254, 9), phnorm_pkg::W_W'({$urandom, $urandom}));
    for (int i = 0; i < 6; i++) send_pixel(rand_pixel());
    drain();
  endtask

  task automatic test_random(input int n_items, input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < n_items; i++) begin
      if (i % 100 == 0 && i != 0) begin
        drain();
        load_random_weights();
      end
      send_pixel(rand_pixel());
    end
    drain();
  endtask

  // stall the receiver long enough to fill the pipe and back up the input
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_random_weights();
    @(posedge clk);
    hold_req++;
    for (int i = 0; i < 80; i++) send_pixel(rand_pixel());
    drain();
  endtask

  initial begin
    for (int l = 0; l < N_LIGHTS; l++) light_wt[l] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    recv_idle_pct = 0;
    test_reset_weights();
    test_directed();
    test_bad_index();
    test_random(350, 34, 73);
    test_random(350, 73, 34);
    test_backpressure();
    test_random(350, 0, 0);
    if (mismatches == 0 && normal_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
`default_nettype wire
